[rtl/core/shc_pkg.sv]
// Shared types, constants and colour table of the score heat-map colouriser.
package shc_pkg;

   localparam int SCORE_W   = 24;
   localparam int NUM_W     = 35;
   localparam int DEN_W     = 36;
   localparam int ROOT_W    = 18;
   localparam int KEY_W     = 8;
   localparam int LEVEL_W   = 2;
   localparam int IX_W      = 4;

   localparam logic [ROOT_W-1:0]  ROOT_SCALE  = 18'd260100;
   localparam logic [SCORE_W-1:0] GOOD_RESET  = 24'd65536;
   localparam logic [SCORE_W-1:0] BAD_RESET   = 24'd131072;

   typedef enum logic [1:0] {
      REGION_LOW,
      REGION_MID,
      REGION_HIGH
   } region_type;

   typedef enum logic {
      CSR_GOOD = 1'b0,
      CSR_BAD  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               pixel_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } rsp_payload_type;

   // Colour table in units of one half, packed as {red, green, blue}
   function automatic logic [3*LEVEL_W-1:0] heat_entry(input logic [IX_W-1:0] ix);
      logic [3*LEVEL_W-1:0] e;
      case (ix)
         4'd0:    e = {2'd0, 2'd0, 2'd0};
         4'd1:    e = {2'd0, 2'd0, 2'd2};
         4'd2:    e = {2'd0, 2'd2, 2'd2};
         4'd3:    e = {2'd0, 2'd2, 2'd0};
         4'd4:    e = {2'd2, 2'd2, 2'd0};
         4'd5:    e = {2'd2, 2'd0, 2'd0};
         4'd6:    e = {2'd2, 2'd0, 2'd2};
         4'd7:    e = {2'd1, 2'd1, 2'd2};
         4'd8:    e = {2'd2, 2'd1, 2'd1};
         4'd9:    e = {2'd2, 2'd2, 2'd1};
         4'd10:   e = {2'd2, 2'd2, 2'd2};
         4'd11:   e = {2'd2, 2'd2, 2'd2};
         default: e = {2'd0, 2'd0, 2'd0};
      endcase
      return e;
   endfunction

endpackage

[rtl/core/shc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module shc_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic                           in_last,
   input  logic [shc_pkg::NUM_W-1:0]      in_num,
   input  logic [shc_pkg::DEN_W-1:0]      in_den,
   input  logic                           in_sat,
   output logic                           out_valid,
   output logic                           out_last,
   output logic [FRAC_BITS+3:0]           out_quot,
   output logic                           out_sat
);
   import shc_pkg::*;

   localparam int Q_W  = FRAC_BITS + 4;
   localparam int HI_W = NUM_W - 4;

   logic             vld_ff  [0:Q_W];
   logic             last_ff [0:Q_W];
   logic             sat_ff  [0:Q_W];
   logic [DEN_W-1:0] rem_ff  [0:Q_W-1];
   logic [DEN_W-1:0] den_ff  [0:Q_W-1];
   logic [3:0]       low_ff  [0:3];
   logic [Q_W-1:0]   q_ff    [1:Q_W];

   logic [DEN_W-1:0] head_in;
   logic             sat_in;

   // Flag quotients that do not fit the quotient width
   assign head_in = {{(DEN_W-HI_W){1'b0}}, in_num[NUM_W-1:4]};
   assign sat_in  = in_sat || (head_in >= in_den);

   // Entry stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff[0] <= in_last;
         sat_ff[0]  <= sat_in;
         rem_ff[0]  <= head_in;
         den_ff[0]  <= in_den;
         low_ff[0]  <= in_num[3:0];
      end
   end

   // One quotient bit per stage
   for (genvar i = 0; i < Q_W; i++) begin : g_step
      logic             bit_in;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W:0]   rem_sub;
      logic             ge;
      logic [Q_W-1:0]   q_prev;

      if (i < 4) begin : g_low
         assign bit_in = low_ff[i][3-i];
      end else begin : g_zero
         assign bit_in = 1'b0;
      end

      if (i == 0) begin : g_q0
         assign q_prev = '0;
      end else begin : g_qn
         assign q_prev = q_ff[i];
      end

      assign rem_sh  = {rem_ff[i], bit_in};
      assign ge      = rem_sh >= {1'b0, den_ff[i]};
      assign rem_sub = rem_sh - {1'b0, den_ff[i]};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            last_ff[i+1] <= last_ff[i];
            sat_ff[i+1]  <= sat_ff[i];
            q_ff[i+1]    <= {q_prev[Q_W-2:0], ge};
         end
      end

      if (i < Q_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[i+1] <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
               den_ff[i+1] <= den_ff[i];
            end
         end
      end

      if (i < 3) begin : g_lowcarry
         always_ff @(posedge clock) begin
            if (advance) begin
               low_ff[i+1] <= low_ff[i];
            end
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_last  = last_ff[Q_W];
   assign out_sat   = sat_ff[Q_W];
   assign out_quot  = q_ff[Q_W];

endmodule

[rtl/core/shc_root.sv]
// Pipelined rounded square-root search, one result bit per stage.
module shc_root (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [shc_pkg::ROOT_W-1:0]  in_x,
   output logic [shc_pkg::KEY_W-1:0]   out_k
);
   import shc_pkg::*;

   logic [ROOT_W-1:0] x_ff [0:KEY_W-1];
   logic [KEY_W-1:0]  k_ff [0:KEY_W-1];

   // Keep the largest k with (2k-1)^2 not above x
   for (genvar j = 0; j < KEY_W; j++) begin : g_bit
      logic [ROOT_W-1:0] x_cur;
      logic [KEY_W-1:0]  k_prev;
      logic [KEY_W-1:0]  cand;
      logic [KEY_W:0]    odd;
      logic [ROOT_W-1:0] sq;

      if (j == 0) begin : g_first
         assign x_cur  = in_x;
         assign k_prev = '0;
      end else begin : g_next
         assign x_cur  = x_ff[j-1];
         assign k_prev = k_ff[j-1];
      end

      assign cand = k_prev | (KEY_W'(1) << (KEY_W - 1 - j));
      assign odd  = {cand, 1'b0} - (KEY_W+1)'(1);
      // Widen before squaring so the product keeps all its bits
      assign sq   = ROOT_W'(odd) * ROOT_W'(odd);

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[j] <= x_cur;
            k_ff[j] <= (sq <= x_cur) ? cand : k_prev;
         end
      end
   end

   assign out_k = k_ff[KEY_W-1];

endmodule

[rtl/core/score_heatmap_colorizer.sv]
// Top level of the score heat-map colouriser.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// The divider (one quotient bit per stage) and the root search (one bit per stage) set the depth.
// Reset clears all valid bits and loads the threshold registers with their defaults.
module score_heatmap_colorizer #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  shc_pkg::req_payload_type   req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output shc_pkg::rsp_payload_type   rsp_data,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [2:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import shc_pkg::*;

   localparam int Q_W = FRAC_BITS + 4;
   localparam int V_W = FRAC_BITS + 2;
   localparam int P_W = V_W + ROOT_W;
   localparam logic [FRAC_BITS:0] ONE_VAL = (FRAC_BITS+1)'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0] T_MAX = Q_W'(10) << FRAC_BITS;
   localparam logic [Q_W-1:0] T_DIV = T_MAX / 11;

   // Scale a fraction by a table level of 0, 1 or 2 halves
   function automatic logic [V_W-1:0] scale_level(input logic [FRAC_BITS:0] a,
                                                  input logic [LEVEL_W-1:0] lvl);
      logic [V_W-1:0] r;
      case (lvl)
         2'd1:    r = V_W'(a);
         2'd2:    r = {a, 1'b0};
         default: r = '0;
      endcase
      return r;
   endfunction

   logic               advance;
   logic [SCORE_W-1:0] good_ff;
   logic [SCORE_W-1:0] bad_ff;
   logic               csr_wr;
   csr_index_type      csr_idx;

   // Configuration registers
   assign csr_idx    = csr_index_type'(csr_paddr[2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         good_ff <= GOOD_RESET;
         bad_ff  <= BAD_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_GOOD: good_ff <= csr_pwdata[SCORE_W-1:0];
            CSR_BAD:  bad_ff  <= csr_pwdata[SCORE_W-1:0];
            default:  good_ff <= good_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_GOOD: csr_prdata = {{(32-SCORE_W){1'b0}}, good_ff};
         CSR_BAD:  csr_prdata = {{(32-SCORE_W){1'b0}}, bad_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // Hold every stage while the result register is stalled
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 1: pick the region and its operands
   logic               p1_vld_ff;
   logic               p1_last_ff;
   region_type         p1_region_ff;
   logic [SCORE_W-1:0] p1_diff_ff;
   logic [SCORE_W-1:0] p1_base_ff;
   region_type         p1_region_in;
   logic [SCORE_W-1:0] p1_diff_in;
   logic [SCORE_W-1:0] p1_base_in;

   always_comb begin
      if (req_data.score < good_ff) begin
         p1_region_in = REGION_LOW;
         p1_diff_in   = req_data.score;
         p1_base_in   = good_ff;
      end else if (req_data.score < bad_ff) begin
         p1_region_in = REGION_MID;
         p1_diff_in   = req_data.score - good_ff;
         p1_base_in   = bad_ff - good_ff;
      end else begin
         p1_region_in = REGION_HIGH;
         p1_diff_in   = req_data.score - bad_ff;
         p1_base_in   = bad_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (advance) begin
         p1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_last_ff   <= req_data.pixel_last;
         p1_region_ff <= p1_region_in;
         p1_diff_ff   <= p1_diff_in;
         p1_base_ff   <= p1_base_in;
      end
   end

   // Stage 2: form numerator and denominator of the position
   logic             p2_vld_ff;
   logic             p2_last_ff;
   logic             p2_sat_ff;
   logic [NUM_W-1:0] p2_num_ff;
   logic [DEN_W-1:0] p2_den_ff;
   logic [NUM_W-1:0] p2_num_in;
   logic [DEN_W-1:0] p2_den_in;
   logic             p2_sat_in;

   always_comb begin
      p2_sat_in = 1'b0;
      case (p1_region_ff)
         REGION_LOW: begin
            p2_num_in = NUM_W'(p1_diff_ff) * NUM_W'(3);
            p2_den_in = DEN_W'(p1_base_ff) * DEN_W'(10);
         end
         REGION_MID: begin
            p2_num_in = NUM_W'(p1_base_ff) * NUM_W'(30) + NUM_W'(p1_diff_ff) * NUM_W'(15);
            p2_den_in = DEN_W'(p1_base_ff) * DEN_W'(100);
         end
         default: begin
            p2_num_in = NUM_W'(p1_base_ff) * NUM_W'(1080)
                      + NUM_W'(p1_diff_ff) * NUM_W'(100);
            p2_den_in = DEN_W'(p1_base_ff) * DEN_W'(2400);
            p2_sat_in = (p1_base_ff == '0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (advance) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_last_ff <= p1_last_ff;
         p2_sat_ff  <= p2_sat_in;
         p2_num_ff  <= p2_num_in;
         p2_den_ff  <= p2_den_in;
      end
   end

   // Divide
   logic           dv_vld;
   logic           dv_last;
   logic           dv_sat;
   logic [Q_W-1:0] dv_quot;

   shc_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p2_vld_ff),
      .in_last   (p2_last_ff),
      .in_num    (p2_num_ff),
      .in_den    (p2_den_ff),
      .in_sat    (p2_sat_ff),
      .out_valid (dv_vld),
      .out_last  (dv_last),
      .out_quot  (dv_quot),
      .out_sat   (dv_sat)
   );

   // Stage T: scale by eleven, saturate, split into index and fraction
   logic                 t_vld_ff;
   logic                 t_last_ff;
   logic [IX_W-1:0]      t_ix_ff;
   logic [FRAC_BITS-1:0] t_frac_ff;
   logic [Q_W-1:0]       t_in;

   assign t_in = (dv_sat || (dv_quot > T_DIV)) ? T_MAX : Q_W'(dv_quot * Q_W'(11));

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (advance) begin
         t_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_last_ff <= dv_last;
         t_ix_ff   <= t_in[Q_W-1:FRAC_BITS];
         t_frac_ff <= t_in[FRAC_BITS-1:0];
      end
   end

   // Stage V: interpolate between table entries
   logic                 v_vld_ff;
   logic                 v_last_ff;
   logic [V_W-1:0]       v_ff [0:2];
   logic [3*LEVEL_W-1:0] lo_entry;
   logic [3*LEVEL_W-1:0] hi_entry;
   logic [FRAC_BITS:0]   frac_ext;
   logic [FRAC_BITS:0]   frac_inv;

   assign lo_entry = heat_entry(t_ix_ff);
   assign hi_entry = heat_entry(t_ix_ff + IX_W'(1));
   assign frac_ext = {1'b0, t_frac_ff};
   assign frac_inv = ONE_VAL - frac_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else if (advance) begin
         v_vld_ff <= t_vld_ff;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      localparam int SH = (2 - c) * LEVEL_W;
      logic [V_W-1:0]    v_in;
      logic [P_W-1:0]    prod;
      logic [ROOT_W-1:0] x_ff;

      assign v_in = scale_level(frac_ext, hi_entry[SH +: LEVEL_W])
                  + scale_level(frac_inv, lo_entry[SH +: LEVEL_W]);

      always_ff @(posedge clock) begin
         if (advance) begin
            v_ff[c] <= v_in;
         end
      end

      // Stage X: bring 255^2 * 4 * v down to an integer bound
      assign prod = P_W'(v_ff[c]) * P_W'(ROOT_SCALE);

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff <= prod[FRAC_BITS+1 +: ROOT_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_last_ff <= t_last_ff;
      end
   end

   logic x_vld_ff;
   logic x_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
      end else if (advance) begin
         x_vld_ff <= v_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_last_ff <= v_last_ff;
      end
   end

   // Root search, one unit per channel
   logic [KEY_W-1:0] k_red;
   logic [KEY_W-1:0] k_green;
   logic [KEY_W-1:0] k_blue;

   shc_root u_root_red (
      .clock   (clock),
      .advance (advance),
      .in_x    (g_chan[0].x_ff),
      .out_k   (k_red)
   );

   shc_root u_root_green (
      .clock   (clock),
      .advance (advance),
      .in_x    (g_chan[1].x_ff),
      .out_k   (k_green)
   );

   shc_root u_root_blue (
      .clock   (clock),
      .advance (advance),
      .in_x    (g_chan[2].x_ff),
      .out_k   (k_blue)
   );

   // Carry valid and last flag alongside the root stages
   logic rv_ff [0:KEY_W-1];
   logic rl_ff [0:KEY_W-1];

   for (genvar j = 0; j < KEY_W; j++) begin : g_rtag
      logic v_prev;
      logic l_prev;

      if (j == 0) begin : g_first
         assign v_prev = x_vld_ff;
         assign l_prev = x_last_ff;
      end else begin : g_next
         assign v_prev = rv_ff[j-1];
         assign l_prev = rl_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[j] <= 1'b0;
         end else if (advance) begin
            rv_ff[j] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rl_ff[j] <= l_prev;
         end
      end
   end

   // Result
   assign rsp_valid          = rv_ff[KEY_W-1];
   assign rsp_data.red       = k_red;
   assign rsp_data.green     = k_green;
   assign rsp_data.blue      = k_blue;
   assign rsp_data.frame_end = rl_ff[KEY_W-1];

endmodule
